>>> rtl/aabb_pairwise_collision_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the collision table
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AABB_PAIRWISE_COLLISION_TABLE_MACROS_SVH
`define AABB_PAIRWISE_COLLISION_TABLE_MACROS_SVH

// property must hold at every edge
`define AABB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true
`define AABB_ASSERT_NEVER(label, expr, msg) \
  `AABB_ASSERT(label, !(expr), msg)

`endif

>>> rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Types, codes and helpers shared by the collision table modules.
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int unsigned SLOTS   = 8;
  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SIZE_W  = 15;
  localparam int unsigned EDGE_W  = 18;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned PE_W    = 16;

  localparam logic [PE_W-1:0] PAIR_ENABLE_RST = 16'd3026;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MARK  = 2'd1,
    OP_SWEEP = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_ACK  = 2'd0,
    RES_FULL = 2'd1,
    RES_HIT  = 2'd2,
    RES_DONE = 2'd3
  } res_e;

  typedef struct packed {
    op_e                       operation;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic [SIZE_W-1:0]         box_w;
    logic [SIZE_W-1:0]         box_h;
    logic [KIND_W-1:0]         kind;
    logic                      notify;
    logic [IDX_W-1:0]          slot;
  } aabb_req_t;

  typedef struct packed {
    res_e             event_res;
    logic [IDX_W-1:0] self_slot;
    logic [IDX_W-1:0] other_slot;
    logic             last;
  } aabb_res_t;

  // one stored box; occ doubles as the valid bit when used as a probe
  typedef struct packed {
    logic                      occ;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
    logic [KIND_W-1:0]         kind;
    logic                      notify;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic mark;
    logic clear;
    logic prune;
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic [SLOTS-1:0]  add_sel;
    logic [SLOTS-1:0]  mark_sel;
    logic [SLOTS-1:0]  load_sel;
    logic              clear;
    logic              prune;
    logic              shift;
    logic [SLOT_W-1:0] probe_idx;
  } seq_ctl_t;

  typedef struct packed {
    logic fwd;
    logic rev;
  } cell_hit_t;

  // far edge of a box, exact
  function automatic logic signed [EDGE_W-1:0] far_edge(
    input logic signed [COORD_W-1:0] pos,
    input logic [SIZE_W-1:0]         len
  );
    logic signed [EDGE_W-1:0] p;
    logic signed [EDGE_W-1:0] l;
    p = EDGE_W'(pos);
    l = signed'({{(EDGE_W-SIZE_W){1'b0}}, len});
    return p + l;
  endfunction

endpackage

>>> rtl/aabb_cell.sv
// ----------------------------------------------------------------------------
// aabb_cell
// One slot of the table: stored box plus a probe stage of the sweep chain.
// ----------------------------------------------------------------------------
module aabb_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aabb_pkg::cell_ctl_t ctl_i,
  input  aabb_pkg::aabb_req_t req_i,
  input  logic [15:0]        pair_enable_i,
  input  aabb_pkg::entry_t   probe_load_i,
  input  aabb_pkg::entry_t   probe_i,
  output aabb_pkg::entry_t   probe_o,
  output aabb_pkg::entry_t   entry_o,
  output aabb_pkg::cell_hit_t hit_o
);
  import aabb_pkg::*;

  logic   occ_q;
  logic   pend_q;
  logic   probe_vld_q;
  entry_t box_q;
  entry_t probe_q;

  logic signed [EDGE_W-1:0] a_x, a_y, a_xe, a_ye;
  logic signed [EDGE_W-1:0] b_x, b_y, b_xe, b_ye;
  logic                     overlap;
  logic [3:0]               fwd_bit, rev_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= 1'b0;
      pend_q      <= 1'b0;
      probe_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        occ_q  <= 1'b0;
        pend_q <= 1'b0;
      end else if (ctl_i.wr) begin
        occ_q  <= 1'b1;
        pend_q <= 1'b0;
      end else if (ctl_i.prune) begin
        if (pend_q) begin
          occ_q <= 1'b0;
        end
        pend_q <= 1'b0;
      end else if (ctl_i.mark && occ_q) begin
        pend_q <= 1'b1;
      end

      if (ctl_i.load) begin
        probe_vld_q <= probe_load_i.occ;
      end else if (ctl_i.shift) begin
        probe_vld_q <= probe_i.occ;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      box_q.occ    <= 1'b1;
      box_q.x      <= req_i.box_x;
      box_q.y      <= req_i.box_y;
      box_q.w      <= req_i.box_w;
      box_q.h      <= req_i.box_h;
      box_q.kind   <= req_i.kind;
      box_q.notify <= req_i.notify;
    end
    if (ctl_i.load) begin
      probe_q <= probe_load_i;
    end else if (ctl_i.shift) begin
      probe_q <= probe_i;
    end
  end

  // probe box is the lower slot (receiver of the forward event)
  always_comb begin
    a_x  = EDGE_W'(probe_q.x);
    a_y  = EDGE_W'(probe_q.y);
    a_xe = far_edge(probe_q.x, probe_q.w);
    a_ye = far_edge(probe_q.y, probe_q.h);
    b_x  = EDGE_W'(box_q.x);
    b_y  = EDGE_W'(box_q.y);
    b_xe = far_edge(box_q.x, box_q.w);
    b_ye = far_edge(box_q.y, box_q.h);
    overlap = (b_xe > a_x) && (b_x < a_xe) && (b_ye > a_y) && (b_y < a_ye)
              && probe_vld_q && occ_q;
    fwd_bit   = {probe_q.kind, box_q.kind};
    rev_bit   = {box_q.kind, probe_q.kind};
    hit_o.fwd = overlap && probe_q.notify && pair_enable_i[fwd_bit];
    hit_o.rev = overlap && box_q.notify && pair_enable_i[rev_bit];
  end

  always_comb begin
    probe_o     = probe_q;
    probe_o.occ = probe_vld_q;
    entry_o     = box_q;
    entry_o.occ = occ_q;
  end

endmodule

>>> rtl/aabb_seq.sv
// ----------------------------------------------------------------------------
// aabb_seq
// Request decode, sweep sequencer and registered result port.
// ----------------------------------------------------------------------------
module aabb_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  aabb_pkg::aabb_req_t           req_i,
  input  logic [aabb_pkg::SLOTS-1:0]    occ_i,
  input  logic [aabb_pkg::SLOTS-1:0]    hit_fwd_i,
  input  logic [aabb_pkg::SLOTS-1:0]    hit_rev_i,
  output aabb_pkg::seq_ctl_t            ctl_o,
  output logic                          res_strobe_o,
  output aabb_pkg::aabb_res_t           res_o
);
  import aabb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [SLOT_W-1:0] LAST_K = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] LAST_I = SLOT_W'(SLOTS - 2);

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] i_q, i_d, k_q, k_d;
  logic              ph_q, ph_d;
  logic              strobe_q, strobe_d;
  aabb_res_t         res_q, res_d;

  logic              accept;
  logic              add_found;
  logic [SLOT_W-1:0] add_idx;
  logic [SLOT_W-1:0] k_first;
  logic              load_now;
  logic              fa, fb;
  logic              advance;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // lowest free slot
  always_comb begin
    add_found = 1'b0;
    add_idx   = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!occ_i[j]) begin
        add_found = 1'b1;
        add_idx   = SLOT_W'(j);
      end
    end
  end

  assign k_first  = i_q + SLOT_W'(1);
  assign load_now = (state_q == ST_LOAD) && occ_i[i_q];
  assign fa       = hit_fwd_i[k_q];
  assign fb       = hit_rev_i[k_q];

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      ctl_o.add_sel[j]  = accept && (req_i.operation == OP_ADD) && add_found
                          && (add_idx == SLOT_W'(j));
      ctl_o.mark_sel[j] = accept && (req_i.operation == OP_MARK)
                          && (req_i.slot == IDX_W'(j));
      ctl_o.load_sel[j] = load_now && (k_first == SLOT_W'(j));
    end
    ctl_o.clear     = accept && (req_i.operation == OP_CLEAR);
    ctl_o.prune     = accept && (req_i.operation == OP_SWEEP);
    ctl_o.shift     = advance;
    ctl_o.probe_idx = i_q;
  end

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    k_d      = k_q;
    ph_d     = ph_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    advance  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          strobe_d         = 1'b1;
          res_d.event_res  = RES_ACK;
          res_d.self_slot  = '0;
          res_d.other_slot = '0;
          res_d.last       = 1'b1;
          unique case (req_i.operation)
            OP_ADD: begin
              if (add_found) begin
                res_d.self_slot = IDX_W'(add_idx);
              end else begin
                res_d.event_res = RES_FULL;
              end
            end
            OP_MARK: begin
              res_d.self_slot = req_i.slot;
            end
            OP_CLEAR: begin
              res_d.self_slot = '0;
            end
            OP_SWEEP: begin
              strobe_d = 1'b0;
              i_d      = '0;
              ph_d     = 1'b0;
              state_d  = ST_LOAD;
            end
          endcase
        end
      end
      ST_LOAD: begin
        if (occ_i[i_q]) begin
          k_d     = k_first;
          ph_d    = 1'b0;
          state_d = ST_WALK;
        end else if (i_q == LAST_I) begin
          state_d = ST_DONE;
        end else begin
          i_d = i_q + SLOT_W'(1);
        end
      end
      ST_WALK: begin
        res_d.event_res = RES_HIT;
        res_d.last      = 1'b0;
        if (ph_q) begin
          strobe_d         = 1'b1;
          res_d.self_slot  = IDX_W'(k_q);
          res_d.other_slot = IDX_W'(i_q);
          ph_d             = 1'b0;
          advance          = 1'b1;
        end else if (fa) begin
          strobe_d         = 1'b1;
          res_d.self_slot  = IDX_W'(i_q);
          res_d.other_slot = IDX_W'(k_q);
          if (fb) begin
            ph_d = 1'b1;
          end else begin
            advance = 1'b1;
          end
        end else if (fb) begin
          strobe_d         = 1'b1;
          res_d.self_slot  = IDX_W'(k_q);
          res_d.other_slot = IDX_W'(i_q);
          advance          = 1'b1;
        end else begin
          advance = 1'b1;
        end

        if (advance) begin
          if (k_q != LAST_K) begin
            k_d = k_q + SLOT_W'(1);
          end else if (i_q == LAST_I) begin
            state_d = ST_DONE;
          end else begin
            i_d     = i_q + SLOT_W'(1);
            state_d = ST_LOAD;
          end
        end
      end
      ST_DONE: begin
        strobe_d         = 1'b1;
        res_d.event_res  = RES_DONE;
        res_d.self_slot  = '0;
        res_d.other_slot = '0;
        res_d.last       = 1'b1;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      i_q      <= '0;
      k_q      <= '0;
      ph_q     <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      k_q      <= k_d;
      ph_q     <= ph_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

>>> rtl/aabb_pairwise_collision_table.sv
// ----------------------------------------------------------------------------
// aabb_pairwise_collision_table
// Table of eight axis-aligned boxes with a pairwise overlap sweep.
// ----------------------------------------------------------------------------
// Add, mark and clear requests give their single result in the cycle after
// they are taken, and a new request may follow straight away. A sweep holds
// busy high while a probe copy of each occupied box in slots 0 to 6 walks
// along the row of slot cells, one cell per cycle, testing one pair per
// cycle, except that a pair raising events in both directions holds the
// probe for its second event. The sweep visits each lower slot 0 to 6 in
// turn, occupied or not, walking the probe of an occupied one past every
// higher slot; then it gives the done result, which shows in the cycle where
// busy drops. Results come with res_strobe_o for one cycle and cannot be
// held off by the receiver.
`include "aabb_pairwise_collision_table_macros.svh"

module aabb_pairwise_collision_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  aabb_pkg::aabb_req_t req_i,
  output logic                res_strobe_o,
  output aabb_pkg::aabb_res_t res_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);
  import aabb_pkg::*;

  logic [PE_W-1:0]  pair_enable_q;
  seq_ctl_t         seq_ctl;
  entry_t           entry   [SLOTS];
  entry_t           probe   [SLOTS];
  cell_hit_t        hit     [SLOTS];
  entry_t           probe_load;
  logic [SLOTS-1:0] occ, hit_fwd, hit_rev, probe_vld;
  logic             single_req;
  logic             done_out;
  logic             hit_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_enable_q <= PAIR_ENABLE_RST;
    end else if (cfg_we_i) begin
      pair_enable_q <= cfg_wdata_i;
    end
  end

  assign probe_load = entry[seq_ctl.probe_idx];

  for (genvar j = 0; j < SLOTS; j++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    probe_in;

    always_comb begin
      ctl.wr    = seq_ctl.add_sel[j];
      ctl.mark  = seq_ctl.mark_sel[j];
      ctl.clear = seq_ctl.clear;
      ctl.prune = seq_ctl.prune;
      ctl.load  = seq_ctl.load_sel[j];
      ctl.shift = seq_ctl.shift;
    end

    if (j == 0) begin : g_head
      assign probe_in = '0;
    end else begin : g_link
      assign probe_in = probe[j-1];
    end

    aabb_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .req_i        (req_i),
      .pair_enable_i(pair_enable_q),
      .probe_load_i (probe_load),
      .probe_i      (probe_in),
      .probe_o      (probe[j]),
      .entry_o      (entry[j]),
      .hit_o        (hit[j])
    );

    assign occ[j]       = entry[j].occ;
    assign hit_fwd[j]   = hit[j].fwd;
    assign hit_rev[j]   = hit[j].rev;
    assign probe_vld[j] = probe[j].occ;
  end

  aabb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .occ_i       (occ),
    .hit_fwd_i   (hit_fwd),
    .hit_rev_i   (hit_rev),
    .ctl_o       (seq_ctl),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  assign single_req = start && !busy && (req_i.operation != OP_SWEEP);
  assign done_out   = res_strobe_o && (res_o.event_res == RES_DONE);
  assign hit_out    = res_strobe_o && (res_o.event_res == RES_HIT);

  // only one probe copy may be in the row at a time
  `AABB_ASSERT(a_single_probe, $onehot0(probe_vld), "more than one probe in the cell row")
  `AABB_ASSERT(a_quick_ack, single_req |=> (res_strobe_o && res_o.last), "request without result")
  `AABB_ASSERT(a_sweep_ends_done, $fell(busy) |-> done_out, "sweep ended without done result")
  `AABB_ASSERT_NEVER(a_no_self_hit, hit_out && (res_o.self_slot == res_o.other_slot), "self hit")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, mark, sweep and clear requests into the box collision table.
// A short directed list goes first, then random traffic under several
// pair-enable settings. Typed list rows are checked against their listed
// results, all others against a behavioural copy of the slot table and sweep.
// ----------------------------------------------------------------------------
module testbench;
  import aabb_pkg::*;

  localparam int SLOT_COUNT       = int'(SLOTS);
  localparam int PLAN_LEN         = 23;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 44;
  localparam int SETTLE_CYCLES    = 80;

  typedef struct packed {
    aabb_req_t req;
    logic      typed;
    aabb_res_t want;
  } plan_row_t;

  localparam aabb_res_t NO_RES = '{RES_ACK, 3'd0, 3'd0, 1'b0};

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  aabb_req_t   req       = '0;
  logic        res_strobe;
  aabb_res_t   res;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;

  always #5 clk_i = ~clk_i;

  aabb_pairwise_collision_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_strobe_o(res_strobe),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // directed list: extremes, every kind, full table, touching edges, empty box
  plan_row_t plan [PLAN_LEN] = '{
    '{'{OP_SWEEP, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd0}, 1'b1,
      '{RES_DONE, 3'd0, 3'd0, 1'b1}},
    '{'{OP_MARK, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd5}, 1'b1,
      '{RES_ACK, 3'd5, 3'd0, 1'b1}},
    '{'{OP_ADD, 16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 2'd0, 1'b1, 3'd0}, 1'b1,
      '{RES_ACK, 3'd0, 3'd0, 1'b1}},
    '{'{OP_ADD, 16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 2'd1, 1'b1, 3'd7}, 1'b1,
      '{RES_ACK, 3'd1, 3'd0, 1'b1}},
    '{'{OP_ADD, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd2, 1'b0, 3'd0}, 1'b1,
      '{RES_ACK, 3'd2, 3'd0, 1'b1}},
    '{'{OP_ADD, -16'sd10, -16'sd10, 15'd20, 15'd20, 2'd3, 1'b1, 3'd0}, 1'b1,
      '{RES_ACK, 3'd3, 3'd0, 1'b1}},
    '{'{OP_ADD, -16'sd5, -16'sd5, 15'd10, 15'd10, 2'd1, 1'b1, 3'd0}, 1'b1,
      '{RES_ACK, 3'd4, 3'd0, 1'b1}},
    '{'{OP_ADD, 16'sd10, -16'sd10, 15'd5, 15'd5, 2'd2, 1'b1, 3'd0}, 1'b1,
      '{RES_ACK, 3'd5, 3'd0, 1'b1}},
    '{'{OP_ADD, 16'sd0, 16'sd0, 15'd1, 15'd1, 2'd0, 1'b1, 3'd0}, 1'b1,
      '{RES_ACK, 3'd6, 3'd0, 1'b1}},
    '{'{OP_ADD, 16'sh8000, 16'sh7fff, 15'd1, 15'd1, 2'd3, 1'b0, 3'd0}, 1'b1,
      '{RES_ACK, 3'd7, 3'd0, 1'b1}},
    '{'{OP_ADD, 16'sd1, 16'sd1, 15'd1, 15'd1, 2'd1, 1'b1, 3'd0}, 1'b1,
      '{RES_FULL, 3'd0, 3'd0, 1'b1}},
    '{'{OP_SWEEP, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd0}, 1'b0, NO_RES},
    '{'{OP_MARK, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd4}, 1'b1,
      '{RES_ACK, 3'd4, 3'd0, 1'b1}},
    '{'{OP_MARK, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd4}, 1'b1,
      '{RES_ACK, 3'd4, 3'd0, 1'b1}},
    '{'{OP_MARK, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd7}, 1'b1,
      '{RES_ACK, 3'd7, 3'd0, 1'b1}},
    '{'{OP_SWEEP, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd0}, 1'b0, NO_RES},
    '{'{OP_ADD, 16'sd3, 16'sd3, 15'd4, 15'd4, 2'd2, 1'b1, 3'd0}, 1'b1,
      '{RES_ACK, 3'd4, 3'd0, 1'b1}},
    '{'{OP_SWEEP, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd0}, 1'b0, NO_RES},
    '{'{OP_MARK, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd0}, 1'b1,
      '{RES_ACK, 3'd0, 3'd0, 1'b1}},
    '{'{OP_CLEAR, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd0}, 1'b1,
      '{RES_ACK, 3'd0, 3'd0, 1'b1}},
    '{'{OP_SWEEP, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd0}, 1'b1,
      '{RES_DONE, 3'd0, 3'd0, 1'b1}},
    '{'{OP_MARK, 16'sd0, 16'sd0, 15'd0, 15'd0, 2'd0, 1'b0, 3'd3}, 1'b1,
      '{RES_ACK, 3'd3, 3'd0, 1'b1}},
    '{'{OP_ADD, -16'sd1, -16'sd1, 15'd2, 15'd2, 2'd1, 1'b1, 3'd0}, 1'b1,
      '{RES_ACK, 3'd0, 3'd0, 1'b1}}
  };

  // table copy
  logic [15:0] pair_en_model;
  bit          slot_used   [SLOT_COUNT];
  bit          slot_doomed [SLOT_COUNT];
  int          box_left    [SLOT_COUNT];
  int          box_top     [SLOT_COUNT];
  int          box_width   [SLOT_COUNT];
  int          box_height  [SLOT_COUNT];
  logic [1:0]  box_kind    [SLOT_COUNT];
  bit          box_notify  [SLOT_COUNT];

  aabb_res_t step_events [$];
  aabb_res_t awaited     [$];

  int idle_pct    = 0;
  int n_requests  = 0;
  int n_results   = 0;
  int n_hits      = 0;
  int n_settings  = 1;
  int mismatches  = 0;

  function automatic aabb_res_t pack_result(res_e code, int self_s, int other_s, bit fin);
    aabb_res_t r;
    r.event_res  = code;
    r.self_slot  = 3'(self_s);
    r.other_slot = 3'(other_s);
    r.last       = fin;
    return r;
  endfunction

  // strict overlap on both axes, a is the receiver
  function automatic bit boxes_overlap(int a, int b);
    return (box_left[b] + box_width[b] > box_left[a]) &&
           (box_left[b] < box_left[a] + box_width[a]) &&
           (box_top[b] + box_height[b] > box_top[a]) &&
           (box_top[b] < box_top[a] + box_height[a]);
  endfunction

  function automatic bit kind_reacts(logic [1:0] row, logic [1:0] col);
    return pair_en_model[{row, col}];
  endfunction

  function automatic void step_table(aabb_req_t r);
    bit placed;
    int s;
    step_events = {};
    placed      = 1'b0;
    case (r.operation)
      OP_ADD: begin
        for (int i = 0; i < SLOT_COUNT && !placed; i++) begin
          if (!slot_used[i]) begin
            slot_used[i]   = 1'b1;
            slot_doomed[i] = 1'b0;
            box_left[i]    = int'(r.box_x);
            box_top[i]     = int'(r.box_y);
            box_width[i]   = int'(r.box_w);
            box_height[i]  = int'(r.box_h);
            box_kind[i]    = r.kind;
            box_notify[i]  = r.notify;
            placed         = 1'b1;
            step_events.push_back(pack_result(RES_ACK, i, 0, 1'b1));
          end
        end
        if (!placed) step_events.push_back(pack_result(RES_FULL, 0, 0, 1'b1));
      end
      OP_MARK: begin
        s = int'(r.slot);
        if (s < SLOT_COUNT && slot_used[s]) slot_doomed[s] = 1'b1;
        step_events.push_back(pack_result(RES_ACK, s, 0, 1'b1));
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          slot_used[i]   = 1'b0;
          slot_doomed[i] = 1'b0;
        end
        step_events.push_back(pack_result(RES_ACK, 0, 0, 1'b1));
      end
      default: begin
        // sweep: prune marked slots, then every pair in ascending order
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_doomed[i]) slot_used[i] = 1'b0;
          slot_doomed[i] = 1'b0;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
          for (int k = i + 1; k < SLOT_COUNT; k++) begin
            if (slot_used[i] && slot_used[k] && boxes_overlap(i, k)) begin
              if (box_notify[i] && kind_reacts(box_kind[i], box_kind[k]))
                step_events.push_back(pack_result(RES_HIT, i, k, 1'b0));
              if (box_notify[k] && kind_reacts(box_kind[k], box_kind[i]))
                step_events.push_back(pack_result(RES_HIT, k, i, 1'b0));
            end
          end
        end
        step_events.push_back(pack_result(RES_DONE, 0, 0, 1'b1));
      end
    endcase
  endfunction

  // adds are the commonest request, mostly of small boxes in a crowded area so that sweeps find overlaps
  function automatic aabb_req_t draw_request();
    aabb_req_t r;
    int pick;
    r.operation = op_e'($urandom_range(3));
    r.box_x     = 16'($urandom);
    r.box_y     = 16'($urandom);
    r.box_w     = 15'($urandom);
    r.box_h     = 15'($urandom);
    r.kind      = 2'($urandom);
    r.notify    = 1'($urandom);
    r.slot      = 3'($urandom);
    pick        = $urandom_range(99);
    if (pick < 45) begin
      r.operation = OP_ADD;
      if ($urandom_range(9) != 0) begin
        r.box_x = 16'(int'($urandom_range(120)) - 60);
        r.box_y = 16'(int'($urandom_range(120)) - 60);
        r.box_w = 15'($urandom_range(50));
        r.box_h = 15'($urandom_range(50));
      end
    end else if (pick < 65) begin
      r.operation = OP_MARK;
    end else if (pick < 88) begin
      r.operation = OP_SWEEP;
    end else if (pick < 93) begin
      r.operation = OP_CLEAR;
    end
    return r;
  endfunction

  task automatic send_request(aabb_req_t r, logic typed, aabb_res_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    step_table(r);
    if (typed) begin
      awaited.push_back(want);
    end else begin
      foreach (step_events[i]) awaited.push_back(step_events[i]);
    end
    n_requests++;
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_pair_enable(logic [15:0] value);
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we        <= 1'b0;
    pair_en_model  = value;
    n_settings++;
  endtask

  always @(posedge clk_i) begin : check_results
    aabb_res_t want;
    if (rst_ni && res_strobe) begin
      n_results++;
      if (res.event_res == RES_HIT) n_hits++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result %0d/%0d/%0d/%0d", $realtime,
                   res.event_res, res.self_slot, res.other_slot, res.last);
      end else begin
        want = awaited.pop_front();
        if (res.event_res !== want.event_res || res.self_slot !== want.self_slot ||
            res.other_slot !== want.other_slot || res.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch, expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     $realtime, want.event_res, want.self_slot, want.other_slot,
                     want.last, res.event_res, res.self_slot, res.other_slot, res.last);
        end
      end
    end
  end

  initial begin
    pair_en_model = PAIR_ENABLE_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 8;
    foreach (plan[i]) send_request(plan[i].req, plan[i].typed, plan[i].want);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_pair_enable(16'hffff);
        1:       write_pair_enable(16'h0000);
        5:       write_pair_enable(PAIR_ENABLE_RST);
        default: write_pair_enable(16'($urandom));
      endcase
      // sender idle rate: light, then heavy, then none
      idle_pct = (p < 2) ? 8 : (p < 4) ? 69 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(29) == 0) wait_all_results();
        send_request(draw_request(), 1'b0, NO_RES);
      end
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Coverage: %0d requests (%0d directed), %0d results, %0d collision events",
             n_requests, PLAN_LEN, n_results, n_hits);
    $display("Coverage: %0d pair-enable settings, %0d mismatches", n_settings, mismatches);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", awaited.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/aabb_pkg.sv
rtl/aabb_cell.sv
rtl/aabb_seq.sv
rtl/aabb_pairwise_collision_table.sv
bench/testbench.sv
